[rtl/apxel_pkg.sv]
// ----------------------------------------------------------------------------
// apxel_pkg
// Shared constants, types and helper functions for the approximate exp/log
// pipeline on IEEE 754 double patterns.
// ----------------------------------------------------------------------------
package apxel_pkg;

	localparam int NUM_STAGES = 10;

	typedef logic [NUM_STAGES:1] en_t;

	typedef enum logic {
		OP_EXP = 1'b0,
		OP_LOG = 1'b1
	} op_t;

	// 2^52 / ln2 as the integer-valued double
	localparam logic [52:0]  A_INT = 53'd6497320848556798;
	// (1023 * 2^20 - 60801) * 2^32
	localparam logic [63:0]  K_INT = ((64'd1023 << 20) - 64'd60801) << 32;

	// 1/A as double: mantissa round(2^105 / A), biased exponent 970
	localparam logic [105:0] P105  = 106'd1 << 105;
	localparam logic [105:0] A_W   = 106'(A_INT);
	localparam logic [105:0] INV_Q = P105 / A_W;
	localparam logic [105:0] INV_R = P105 % A_W;
	localparam logic [52:0]  INV_M = 53'(INV_Q + 106'(((INV_R << 1) > A_W) ||
		(((INV_R << 1) == A_W) && INV_Q[0])));
	localparam logic [10:0]  INV_EXP_OFS = 11'd970;

	localparam logic [63:0]  INF_BITS  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0]  QNAN_BITS = 64'h7FF8_0000_0000_0000;

	// number of significant bits
	function automatic logic [7:0] bitlen130(input logic [129:0] v);
		logic [7:0] n;
		n = 8'd0;
		for (int i = 0; i < 130; i++) begin
			if (v[i]) n = 8'(i + 1);
		end
		return n;
	endfunction

	// round to 53 significant bits, ties to even, value kept in place
	function automatic logic [129:0] round53(input logic [129:0] v, input logic [7:0] len);
		logic [7:0]   sh;
		logic [129:0] mask;
		logic         g;
		logic         st;
		logic         lsb;
		logic         up;
		sh   = (len > 8'd53) ? len - 8'd53 : 8'd0;
		mask = (130'd1 << sh) - 130'd1;
		g    = |(v & (mask ^ (mask >> 1)));
		st   = |(v & (mask >> 1));
		lsb  = |(v & (mask + 130'd1));
		up   = g & (st | lsb);
		return (v & ~mask) + (up ? (mask + 130'd1) : 130'd0);
	endfunction

endpackage

[rtl/apxel_mul53.sv]
// ----------------------------------------------------------------------------
// apxel_mul53
// Two-stage 53x53 unsigned multiplier: four registered partial products,
// then a registered sum.
// ----------------------------------------------------------------------------
module apxel_mul53 (
	input  logic         clk,
	input  logic         en_pp,
	input  logic         en_sum,
	input  logic [52:0]  a,
	input  logic [52:0]  b,
	output logic [105:0] prod
);

	logic [53:0]  pp00_s1;
	logic [52:0]  pp01_s1;
	logic [52:0]  pp10_s1;
	logic [51:0]  pp11_s1;
	logic [105:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en_pp) begin
			pp00_s1 <= {27'b0, a[26:0]} * {27'b0, b[26:0]};
			pp01_s1 <= {26'b0, a[26:0]} * {27'b0, b[52:27]};
			pp10_s1 <= {27'b0, a[52:27]} * {26'b0, b[26:0]};
			pp11_s1 <= {26'b0, a[52:27]} * {26'b0, b[52:27]};
		end
	end

	always_ff @(posedge clk) begin
		if (en_sum) begin
			prod_s2 <= ({pp11_s1, 54'b0}) + ({26'b0, pp01_s1, 27'b0}) +
				({26'b0, pp10_s1, 27'b0}) + ({52'b0, pp00_s1});
		end
	end

	assign prod = prod_s2;

endmodule

[rtl/apxel_exp.sv]
// ----------------------------------------------------------------------------
// apxel_exp
// Exp datapath: A*x in fixed point, add K, one rounding to 53 bits,
// truncation to an integer pattern with saturation.
// ----------------------------------------------------------------------------
module apxel_exp (
	input  logic             clk,
	input  apxel_pkg::en_t   en,
	input  logic [63:0]      operand,
	output logic [63:0]      result_bits,
	output logic             saturated
);

	logic               sx;
	logic [10:0]        ef;
	logic [52:0]        mx;
	logic signed [11:0] ex;
	logic [105:0]       pf;

	assign sx = operand[63];
	assign ef = operand[62:52];
	assign mx = {ef != 11'd0, operand[51:0]};
	assign ex = $signed({1'b0, (ef != 11'd0) ? ef : 11'd1}) - 12'sd1075;

	apxel_mul53 u_mul (
		.clk    (clk),
		.en_pp  (en[2]),
		.en_sum (en[3]),
		.a      (apxel_pkg::A_INT),
		.b      (mx),
		.prod   (pf)
	);

	logic               sx_s2, spec_s2, nan_s2;
	logic signed [11:0] ex_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sx_s2   <= sx;
			ex_s2   <= ex;
			spec_s2 <= (ef == 11'h7FF);
			nan_s2  <= (ef == 11'h7FF) && (operand[51:0] != 52'd0);
		end
	end

	logic               sx_s3, spec_s3, nan_s3;
	logic signed [11:0] ex_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			sx_s3   <= sx_s2;
			ex_s3   <= ex_s2;
			spec_s3 <= spec_s2;
			nan_s3  <= nan_s2;
		end
	end

	// overflow check and fixed-point position
	logic [7:0]         lenp;
	logic signed [12:0] ex13;
	logic               ovf;

	assign lenp = apxel_pkg::bitlen130({24'b0, pf});
	assign ex13 = {ex_s3[11], ex_s3};
	assign ovf  = (lenp != 8'd0) && (($signed({5'b0, lenp}) + ex13) > 13'sd64);

	logic               sx_s4, spec_s4, nan_s4, ovf_s4;
	logic signed [12:0] p_s4;
	logic [105:0]       pf_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sx_s4   <= sx_s3;
			spec_s4 <= spec_s3;
			nan_s4  <= nan_s3;
			ovf_s4  <= ovf;
			p_s4    <= ex13 + 13'sd64;
			pf_s4   <= pf;
		end
	end

	// align to 64 fraction bits, sticky jammed into the lsb
	logic [127:0] ext, fx;
	logic [12:0]  nn;

	always_comb begin
		ext = {22'b0, pf_s4};
		nn  = 13'(-p_s4);
		if (!p_s4[12]) begin
			fx = (p_s4 > 13'sd127) ? 128'd0 : (ext << p_s4[6:0]);
		end else if (nn >= 13'd106) begin
			fx = {127'b0, |pf_s4};
		end else begin
			fx = (ext >> nn[6:0]) |
				{127'b0, |(ext & ((128'd1 << nn[6:0]) - 128'd1))};
		end
	end

	logic         sx_s5, spec_s5, nan_s5, ovf_s5;
	logic [127:0] f_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			sx_s5   <= sx_s4;
			spec_s5 <= spec_s4;
			nan_s5  <= nan_s4;
			ovf_s5  <= ovf_s4;
			f_s5    <= fx;
		end
	end

	// signed sum with K
	logic [128:0] kw, fw, sum;
	logic         neg;

	always_comb begin
		kw = {1'b0, apxel_pkg::K_INT, 64'b0};
		fw = {1'b0, f_s5};
		if (!sx_s5) begin
			sum = kw + fw;
			neg = 1'b0;
		end else if (kw >= fw) begin
			sum = kw - fw;
			neg = 1'b0;
		end else begin
			sum = fw - kw;
			neg = 1'b1;
		end
	end

	logic         sx_s6, spec_s6, nan_s6, ovf_s6, neg_s6;
	logic [128:0] s_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			sx_s6   <= sx_s5;
			spec_s6 <= spec_s5;
			nan_s6  <= nan_s5;
			ovf_s6  <= ovf_s5;
			neg_s6  <= neg;
			s_s6    <= sum;
		end
	end

	logic         sx_s7, spec_s7, nan_s7, ovf_s7, neg_s7;
	logic [128:0] s_s7;
	logic [7:0]   lens_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			sx_s7   <= sx_s6;
			spec_s7 <= spec_s6;
			nan_s7  <= nan_s6;
			ovf_s7  <= ovf_s6;
			neg_s7  <= neg_s6;
			s_s7    <= s_s6;
			lens_s7 <= apxel_pkg::bitlen130({1'b0, s_s6});
		end
	end

	// round, truncate, saturate
	logic [129:0] rnd;
	logic [65:0]  ipart;
	logic [63:0]  res;
	logic         sat;

	always_comb begin
		rnd   = apxel_pkg::round53({1'b0, s_s7}, lens_s7);
		ipart = rnd[129:64];
		if (spec_s7) begin
			res = nan_s7 ? apxel_pkg::QNAN_BITS : (sx_s7 ? 64'd0 : apxel_pkg::INF_BITS);
			sat = !nan_s7;
		end else if (ovf_s7) begin
			res = sx_s7 ? 64'd0 : apxel_pkg::INF_BITS;
			sat = 1'b1;
		end else if (neg_s7) begin
			res = 64'd0;
			sat = (ipart != 66'd0);
		end else if (ipart > {2'b0, apxel_pkg::INF_BITS}) begin
			res = apxel_pkg::INF_BITS;
			sat = 1'b1;
		end else begin
			res = ipart[63:0];
			sat = 1'b0;
		end
	end

	logic [63:0] res_s8, res_s9, res_s10;
	logic        sat_s8, sat_s9, sat_s10;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			res_s8 <= res;
			sat_s8 <= sat;
		end
		if (en[9]) begin
			res_s9 <= res_s8;
			sat_s9 <= sat_s8;
		end
		if (en[10]) begin
			res_s10 <= res_s9;
			sat_s10 <= sat_s9;
		end
	end

	assign result_bits = res_s10;
	assign saturated   = sat_s10;

endmodule

[rtl/apxel_log.sv]
// ----------------------------------------------------------------------------
// apxel_log
// Log datapath: signed integer to double, subtract K, multiply by 1/A,
// each step rounded to nearest even.
// ----------------------------------------------------------------------------
module apxel_log (
	input  logic           clk,
	input  apxel_pkg::en_t en,
	input  logic [63:0]    operand,
	output logic [63:0]    result_bits
);

	logic        neg_s2;
	logic [63:0] mag_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			neg_s2 <= operand[63];
			mag_s2 <= operand[63] ? (64'd0 - operand) : operand;
		end
	end

	logic        neg_s3;
	logic [63:0] mag_s3;
	logic [7:0]  len_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			len_s3 <= apxel_pkg::bitlen130({66'b0, mag_s2});
		end
	end

	logic [129:0] rv;
	logic         neg_s4;
	logic [64:0]  v_s4;

	assign rv = apxel_pkg::round53({66'b0, mag_s3}, len_s3);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			neg_s4 <= neg_s3;
			v_s4   <= rv[64:0];
		end
	end

	// v - K as sign and magnitude
	logic [64:0] kv, dm;
	logic        dsg;

	always_comb begin
		kv = {1'b0, apxel_pkg::K_INT};
		if (neg_s4) begin
			dm  = v_s4 + kv;
			dsg = 1'b1;
		end else if (v_s4 >= kv) begin
			dm  = v_s4 - kv;
			dsg = 1'b0;
		end else begin
			dm  = kv - v_s4;
			dsg = 1'b1;
		end
	end

	logic        dsg_s5;
	logic [64:0] dm_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			dsg_s5 <= dsg;
			dm_s5  <= dm;
		end
	end

	logic        dsg_s6;
	logic [64:0] dm_s6;
	logic [7:0]  lend_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			dsg_s6  <= dsg_s5;
			dm_s6   <= dm_s5;
			lend_s6 <= apxel_pkg::bitlen130({65'b0, dm_s5});
		end
	end

	// normalized mantissa of the rounded difference
	logic [129:0] rd, rdsh;
	logic [7:0]   l2;
	logic [52:0]  md;

	always_comb begin
		rd   = apxel_pkg::round53({65'b0, dm_s6}, lend_s6);
		rdsh = rd >> lend_s6;
		l2   = lend_s6 + {7'b0, rdsh[0]};
		if (l2 <= 8'd53) begin
			md = 53'(rd << (8'd53 - l2));
		end else begin
			md = 53'(rd >> (l2 - 8'd53));
		end
	end

	logic        dsg_s7, zero_s7;
	logic [6:0]  ed_s7;
	logic [52:0] md_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			dsg_s7  <= dsg_s6;
			zero_s7 <= (lend_s6 == 8'd0);
			ed_s7   <= 7'(l2 - 8'd1);
			md_s7   <= md;
		end
	end

	logic [105:0] prod;

	apxel_mul53 u_mul (
		.clk    (clk),
		.en_pp  (en[8]),
		.en_sum (en[9]),
		.a      (md_s7),
		.b      (apxel_pkg::INV_M),
		.prod   (prod)
	);

	logic       dsg_s8, zero_s8, dsg_s9, zero_s9;
	logic [6:0] ed_s8, ed_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			dsg_s8  <= dsg_s7;
			zero_s8 <= zero_s7;
			ed_s8   <= ed_s7;
		end
		if (en[9]) begin
			dsg_s9  <= dsg_s8;
			zero_s9 <= zero_s8;
			ed_s9   <= ed_s8;
		end
	end

	// normalize, round, pack
	logic [52:0] pm;
	logic [53:0] pr;
	logic        g, st, up;
	logic [10:0] bexp;
	logic [63:0] res;

	always_comb begin
		if (prod[105]) begin
			pm = prod[105:53];
			g  = prod[52];
			st = |prod[51:0];
		end else begin
			pm = prod[104:52];
			g  = prod[51];
			st = |prod[50:0];
		end
		up   = g & (st | pm[0]);
		pr   = {1'b0, pm} + {53'b0, up};
		bexp = {4'b0, ed_s9} + apxel_pkg::INV_EXP_OFS + {10'b0, prod[105]} + {10'b0, pr[53]};
		if (zero_s9) begin
			res = 64'd0;
		end else begin
			res = {dsg_s9, bexp, pr[53] ? 52'd0 : pr[51:0]};
		end
	end

	logic [63:0] res_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			res_s10 <= res;
		end
	end

	assign result_bits = res_s10;

endmodule

[rtl/approx_exp_log_double.sv]
// ----------------------------------------------------------------------------
// approx_exp_log_double
// Approximate exp and natural log on IEEE 754 double patterns, ten-stage
// pipeline with per-stage valid bits.
// ----------------------------------------------------------------------------
//  channel | signals                                      | beat
//  --------+----------------------------------------------+---------------------
//  in      | in_valid, in_ready, opcode, operand_bits     | in_valid & in_ready
//  out     | out_valid, out_ready, result_bits, saturated | out_valid & out_ready
//
//  One beat per cycle sustained while out_ready stays high; results pass the
//  two-stage 53x53 multipliers and the normalize/round stages to out_valid.
//  Reset clears only the stage valid bits.
//  Each stage holds only while it is full and the one after it is stalled, so empty
//  stages keep filling while a result waits.
// ----------------------------------------------------------------------------
module approx_exp_log_double (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [63:0] operand_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_bits,
	output logic        saturated
);

	localparam int NS = apxel_pkg::NUM_STAGES;

	logic [NS:1]    vld_q;
	logic [NS+1:1]  rdy;
	apxel_pkg::en_t en;

	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign en = rdy[NS:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	logic [63:0]     operand_s1;
	apxel_pkg::op_t  op_s [1:NS];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			operand_s1 <= operand_bits;
			op_s[1]    <= apxel_pkg::op_t'(opcode);
		end
		for (int k = 2; k <= NS; k++) begin
			if (en[k]) op_s[k] <= op_s[k-1];
		end
	end

	logic [63:0] exp_res, log_res;
	logic        exp_sat;

	apxel_exp u_exp (
		.clk         (clk),
		.en          (en),
		.operand     (operand_s1),
		.result_bits (exp_res),
		.saturated   (exp_sat)
	);

	apxel_log u_log (
		.clk         (clk),
		.en          (en),
		.operand     (operand_s1),
		.result_bits (log_res)
	);

	assign in_ready    = rdy[1];
	assign out_valid   = vld_q[NS];
	assign result_bits = (op_s[NS] == apxel_pkg::OP_LOG) ? log_res : exp_res;
	assign saturated   = (op_s[NS] == apxel_pkg::OP_LOG) ? 1'b0 : exp_sat;

endmodule

[rtl/apxel_chk.sv]
// ----------------------------------------------------------------------------
// apxel_chk
// Port-level checks for approx_exp_log_double, bound to the top level.
// ----------------------------------------------------------------------------
module apxel_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        opcode,
	input logic [63:0] operand_bits,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_bits,
	input logic        saturated
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_bits) && $stable(saturated))
		else $error("result beat changed while stalled");

	// a taken output frees the whole pipe
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			result_bits == 64'd0 || result_bits == apxel_pkg::INF_BITS)
		else $error("saturated result is neither zero nor infinity");

	a_special: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_bits[62:52] == 11'h7FF |->
			result_bits == apxel_pkg::INF_BITS || result_bits == apxel_pkg::QNAN_BITS)
		else $error("non-canonical special result");

endmodule

bind approx_exp_log_double apxel_chk u_chk (.*);

[test/approx_exp_log_double_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approx_exp_log_double_tb
// Streams exp and log beats with random idle bursts on both sides and one long
// output hold-off. A bit-exact model of the exp and log approximations
// predicts each result, and every output beat is checked in order.
// ----------------------------------------------------------------------------
module approx_exp_log_double_tb;

	localparam logic [63:0] A_SCALE = 64'd6497320848556798;
	localparam logic [63:0] K_OFS   = ((64'd1023 << 20) - 64'd60801) << 32;
	localparam int          N_RAND  = 550;
	localparam int          WD_MAX  = 4000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [63:0] operand_bits;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_bits;
	logic        saturated;

	int  n_sent;
	int  n_recv;
	bit  quiet;
	bit  held;
	int  idle_cyc;

	approx_exp_log_double dut (.*);

	class approx_scoreboard;
		logic [64:0] pending_q[$];
		int          errors;

		function automatic int bitlen(logic [255:0] v);
			int n;
			n = 0;
			for (int i = 0; i < 256; i++)
				if (v[i]) n = i + 1;
			return n;
		endfunction

		function automatic logic [64:0] approx_exp(logic [63:0] x);
			logic [255:0] pf, kf, s, half;
			logic [10:0]  ef;
			logic [52:0]  mx;
			logic [255:0] ip;
			int           ex, len, sh, n;
			logic         neg, st, g;
			ef = x[62:52];
			if (ef == 11'h7FF) begin
				if (x[51:0] != 0) return {1'b0, apxel_pkg::QNAN_BITS};
				return {1'b1, x[63] ? 64'd0 : apxel_pkg::INF_BITS};
			end
			mx = (ef != 0) ? {1'b1, x[51:0]} : {1'b0, x[51:0]};
			ex = ((ef != 0) ? int'(ef) : 1) - 1075;
			pf = 256'(A_SCALE) * 256'(mx);
			len = bitlen(pf);
			if (len != 0 && len + ex > 64)
				return {1'b1, x[63] ? 64'd0 : apxel_pkg::INF_BITS};
			if (ex + 64 >= 0) begin
				pf = pf << (ex + 64);
			end else begin
				n = -(ex + 64);
				st = |(pf & ((256'd1 << n) - 256'd1));
				pf = pf >> n;
				if (st) pf[0] = 1'b1;
			end
			kf = 256'(K_OFS) << 64;
			neg = 1'b0;
			if (!x[63]) s = kf + pf;
			else if (kf >= pf) s = kf - pf;
			else begin
				s = pf - kf;
				neg = 1'b1;
			end
			len = bitlen(s);
			if (len > 53) begin
				sh = len - 53;
				half = 256'd1 << (sh - 1);
				g = |(s & half);
				st = |(s & (half - 256'd1));
				s = (s >> sh) << sh;
				if (g && (st || s[sh])) s = s + (256'd1 << sh);
			end
			ip = s >> 64;
			if (neg) return {ip != 0, 64'd0};
			if (ip > 256'(apxel_pkg::INF_BITS)) return {1'b1, apxel_pkg::INF_BITS};
			return {1'b0, ip[63:0]};
		endfunction

		function automatic logic [63:0] int_to_real_bits(logic [63:0] b);
			logic [63:0] mag, m;
			int          len, sh, e;
			logic        g, st;
			mag = b[63] ? -b : b;
			if (mag == 0) return 64'd0;
			len = bitlen(256'(mag));
			if (len <= 53) begin
				m = mag << (53 - len);
				e = -(53 - len);
			end else begin
				sh = len - 53;
				g = mag[sh-1];
				st = |(mag & ((64'd1 << (sh - 1)) - 64'd1));
				m = mag >> sh;
				if (g && (st || m[0])) m = m + 64'd1;
				if (m[53]) begin
					m = m >> 1;
					sh++;
				end
				e = sh;
			end
			return {b[63], 11'(1075 + e), m[51:0]};
		endfunction

		function automatic logic [64:0] approx_log(logic [63:0] b);
			real v, y;
			v = $bitstoreal(int_to_real_bits(b));
			y = (v - $bitstoreal(int_to_real_bits(K_OFS))) *
				(1.0 / $bitstoreal(int_to_real_bits(A_SCALE)));
			return {1'b0, $realtobits(y)};
		endfunction

		function void note_input(apxel_pkg::op_t op, logic [63:0] bits);
			pending_q.push_back(op == apxel_pkg::OP_EXP ? approx_exp(bits) : approx_log(bits));
		endfunction

		function void check_result(logic [63:0] res, logic sat);
			logic [64:0] exp_r;
			if (pending_q.size() == 0) begin
				$error("unexpected result beat %h", res);
				errors++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (exp_r[63:0] !== res) begin
				$error("result_bits expected %h actual %h", exp_r[63:0], res);
				errors++;
			end
			if (exp_r[64] !== sat) begin
				$error("saturated expected %b actual %b", exp_r[64], sat);
				errors++;
			end
		endfunction
	endclass

	approx_scoreboard sb;

	always #6 clk = ~clk;

	task automatic send_beat(apxel_pkg::op_t op, logic [63:0] bits);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		operand_bits <= bits;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(op, bits);
		n_sent++;
	endtask

	function automatic logic [63:0] rand_operand();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return {1'($urandom), 11'($urandom_range(1011, 1033)), 20'($urandom), $urandom};
			2: return {1'($urandom), 11'($urandom_range(0, 2047)), 20'($urandom), $urandom};
			default: return {2'b00, 10'($urandom_range(1000, 1023)), 20'($urandom), $urandom};
		endcase
	endfunction

	// output side: random stall bursts, one long hold-off
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && n_sent > 150) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_result(result_bits, saturated);
			n_recv++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
		else idle_cyc <= idle_cyc + 1;
		if (idle_cyc > WD_MAX) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [63:0] dir_ops[$];
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = apxel_pkg::OP_EXP;
		operand_bits = 64'd0;
		n_sent = 0;
		quiet = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		dir_ops = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
			64'h4086_2000_0000_0000, 64'h4086_3000_0000_0000,
			64'hC087_7000_0000_0000, 64'hC086_2000_0000_0000,
			64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
			64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
			64'hFFEF_FFFF_FFFF_FFFF, 64'h4330_0000_0000_0000};
		foreach (dir_ops[i]) send_beat(apxel_pkg::OP_EXP, dir_ops[i]);
		foreach (dir_ops[i]) if (i < 8) send_beat(apxel_pkg::OP_LOG, dir_ops[i + 8]);
		send_beat(apxel_pkg::OP_LOG, 64'h0);
		for (int i = 0; i < N_RAND; i++) begin
			if (i > N_RAND - 100) quiet = 1'b1;
			send_beat(apxel_pkg::op_t'($urandom_range(0, 1)), rand_operand());
		end
		in_valid <= 1'b0;
		while (n_recv < n_sent) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
